// ----- rtl/tcce_pkg.sv -----
// shared types, codes and defaults of the text console cursor engine
`default_nettype none
package tcce_pkg;

   localparam int COLS_DEF      = 80;
   localparam int ROWS_DEF      = 25;
   localparam int TAB_WIDTH_DEF = 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 1'b1;

   localparam logic [3:0] FG_RESET = 4'hf;
   localparam logic [3:0] BG_RESET = 4'h0;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
   } rsp_type;

   // what a put does besides moving the cursor
   typedef struct packed {
      logic       wr_en;
      logic       wr_at_new;
      logic       scroll;
      logic [7:0] char_byte;
   } put_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/tcce_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/tcce_cursor.sv -----
// cursor move and cell write decision for one put character
`default_nettype none
module tcce_cursor #(
   parameter int COLS      = tcce_pkg::COLS_DEF,
   parameter int ROWS      = tcce_pkg::ROWS_DEF,
   parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
   input  wire logic [7:0]                char_code,
   input  wire logic [$clog2(COLS)-1:0]   cur_col,
   input  wire logic [$clog2(ROWS)-1:0]   cur_row,
   output logic      [$clog2(COLS)-1:0]   nxt_col,
   output logic      [$clog2(ROWS)-1:0]   nxt_row,
   output tcce_pkg::put_ctl_type          ctl
);
   import tcce_pkg::*;

   localparam int CW = $clog2(COLS);
   localparam int RW = $clog2(ROWS);

   logic [CW-1:0] tab_tbl [COLS];
   logic          last_col;
   logic          last_row;

   // next tab stop for every column, clamped to the last column
   for (genvar g = 0; g < COLS; g++) begin : g_tab
      localparam int NXT = ((g / TAB_WIDTH) + 1) * TAB_WIDTH;
      assign tab_tbl[g] = (NXT >= COLS) ? CW'(COLS - 1) : CW'(NXT);
   end

   assign last_col = (cur_col == CW'(COLS - 1));
   assign last_row = (cur_row == RW'(ROWS - 1));

   always_comb begin
      nxt_col       = cur_col;
      nxt_row       = cur_row;
      ctl           = '0;
      ctl.char_byte = char_code;
      unique case (char_code)
         CH_LF: begin
            nxt_col = '0;
            if (last_row) begin
               ctl.scroll = 1'b1;
            end else begin
               nxt_row = cur_row + RW'(1);
            end
         end
         CH_CR: begin
            nxt_col = '0;
         end
         CH_TAB: begin
            nxt_col = tab_tbl[cur_col];
         end
         CH_BS: begin
            ctl.char_byte = CH_SPACE;
            if (cur_col == '0) begin
               // at the origin nothing happens
               if (cur_row != '0) begin
                  nxt_row       = cur_row - RW'(1);
                  nxt_col       = CW'(COLS - 1);
                  ctl.wr_en     = 1'b1;
                  ctl.wr_at_new = 1'b1;
               end
            end else begin
               nxt_col       = cur_col - CW'(1);
               ctl.wr_en     = 1'b1;
               ctl.wr_at_new = 1'b1;
            end
         end
         CH_DEL: begin
            ctl.char_byte = CH_SPACE;
            ctl.wr_en     = 1'b1;
         end
         CH_ESC: begin
         end
         default: begin
            ctl.wr_en = 1'b1;
            if (last_col) begin
               nxt_col = '0;
               if (last_row) begin
                  ctl.scroll = 1'b1;
               end else begin
                  nxt_row = cur_row + RW'(1);
               end
            end else begin
               nxt_col = cur_col + CW'(1);
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/text_console_cursor_engine_top.sv -----
// text console cursor engine: screen store, cursor and sweep sequencer
`default_nettype none
// A put that needs no scroll, an escape, an unused op and an out-of-range read
// finish in the cycle they are accepted; a cell read passes through ST_RDWAIT for
// the registered read port of the screen ram. A clear sweeps the store one cell a
// cycle. A put that scrolls copies (ROWS-1)*COLS cells one a cycle through the
// shared address counter, then fills the bottom row; the fill waits for the last
// copy, since the ram has a single write port. req_ready is low while an item is
// in work and while a result waits that is not being taken.
module text_console_cursor_engine_top #(
   parameter int COLS      = tcce_pkg::COLS_DEF,
   parameter int ROWS      = tcce_pkg::ROWS_DEF,
   parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire tcce_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output tcce_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [tcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcce_pkg::*;

   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [AW-1:0] COLS_A = AW'(COLS);
   localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
   localparam logic [AW-1:0] BOT_A  = AW'((ROWS - 1) * COLS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RDWAIT = 2'd1;
   localparam logic [1:0] ST_SCROLL = 2'd2;
   localparam logic [1:0] ST_FILL   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          cpy_ff, cpy_in;
   logic [AW-1:0] cpy_addr_ff, cpy_addr_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [3:0]    fg_ff, fg_in;
   logic [3:0]    bg_ff, bg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          rd_in_range;
   logic [CW-1:0] nxt_col;
   logic [RW-1:0] nxt_row;
   put_ctl_type   put_ctl;
   logic [RW-1:0] mul_row;
   logic [CW-1:0] mul_col;
   logic [AW-1:0] mul_addr;
   logic [15:0]   fill_cell;
   logic [15:0]   put_cell;
   logic          done;
   logic [15:0]   done_cell;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_rdata;

   tcce_cursor #(
      .COLS      (COLS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_cursor (
      .char_code (req_data.char_code),
      .cur_col   (cur_col_ff),
      .cur_row   (cur_row_ff),
      .nxt_col   (nxt_col),
      .nxt_row   (nxt_row),
      .ctl       (put_ctl)
   );

   tcce_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_in_range = (32'(req_data.read_row) < ROWS) && (32'(req_data.read_col) < COLS);

   // one row*COLS+col address unit, shared by reads and character writes
   always_comb begin
      if (req_data.op == OP_READ) begin
         mul_row = RW'(req_data.read_row);
         mul_col = CW'(req_data.read_col);
      end else if (put_ctl.wr_at_new) begin
         mul_row = nxt_row;
         mul_col = nxt_col;
      end else begin
         mul_row = cur_row_ff;
         mul_col = cur_col_ff;
      end
   end

   assign mul_addr  = AW'(AW'(mul_row) * COLS_A) + AW'(mul_col);
   assign fill_cell = {bg_ff, bg_ff, bg_ff, bg_ff};
   assign put_cell  = {bg_ff, fg_ff, put_ctl.char_byte};

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_in = csr_wdata;
            CSR_BG_COLOR: bg_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cpy_in       = 1'b0;
      cpy_addr_in  = cpy_addr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      done         = 1'b0;
      done_cell    = '0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = fill_cell;
      mem_re       = 1'b0;
      mem_raddr    = addr_ff;

      // copy of a scrolled cell lands in the cycle after its read
      if (cpy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = cpy_addr_ff;
         mem_wdata = mem_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_PUT: begin
                     cur_col_in = nxt_col;
                     cur_row_in = nxt_row;
                     if (put_ctl.wr_en) begin
                        mem_we    = 1'b1;
                        mem_waddr = mul_addr;
                        mem_wdata = put_cell;
                     end
                     if (put_ctl.scroll) begin
                        state_in = ST_SCROLL;
                        addr_in  = COLS_A;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_FILL;
                     addr_in  = '0;
                  end
                  OP_READ: begin
                     if (rd_in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = mul_addr;
                        state_in  = ST_RDWAIT;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            done      = 1'b1;
            done_cell = mem_rdata;
            state_in  = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_re      = 1'b1;
            mem_raddr   = addr_ff;
            cpy_in      = 1'b1;
            cpy_addr_in = addr_ff - COLS_A;
            if (addr_ff == LAST_A) begin
               state_in = ST_FILL;
               addr_in  = BOT_A;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_FILL: begin
            // the fill waits while the last copy holds the write port
            if (!cpy_ff) begin
               mem_we = 1'b1;
               if (addr_ff == LAST_A) begin
                  state_in = ST_IDLE;
                  done     = 1'b1;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rsp_valid_in      = 1'b1;
         rsp_in.cell_value = done_cell;
         rsp_in.cursor_col = 7'(cur_col_in);
         rsp_in.cursor_row = 5'(cur_row_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpy_ff       <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpy_ff       <= cpy_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      cpy_addr_ff <= cpy_addr_in;
      rsp_ff      <= rsp_in;
   end

   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_col_ff) < COLS) && (32'(cur_row_ff) < ROWS))
      else $error("cursor outside the screen");

   a_copy_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cpy_ff |-> (state_ff == ST_SCROLL || state_ff == ST_FILL))
      else $error("scroll copy pending outside a sweep");

   a_cursor_still_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> ($stable(cur_col_ff) && $stable(cur_row_ff)))
      else $error("cursor moved during a sweep or read");

   a_read_goes_to_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_READ && rd_in_range) |=> (state_ff == ST_RDWAIT))
      else $error("in-range read did not wait for ram data");

   a_fill_end_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && !cpy_ff && addr_ff == LAST_A) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("sweep ended without a result");

endmodule
`default_nettype wire
